// ----- src/dld_pkg.sv -----
// Shared types and constants for the doubly linked deque.
package dld_pkg;

    localparam int DLD_DEPTH = 64;
    localparam int VALUE_W   = 32;

    typedef enum logic [2:0] {
        REQ_LIST       = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4,
        REQ_REMOVE     = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Operation broadcast to every cell of the chain at once.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHL,
        OP_SHR,
        OP_LOAD,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [VALUE_W-1:0]  data;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIST,
        ST_FIND,
        ST_REPORT
    } ctrl_state_t;

endpackage

// ----- src/doubly_linked_deque.sv -----
// Top level of the deque: a chain of value cells driven by the request sequencer.
//
// The deque keeps up to DEPTH signed 32-bit elements packed in a row of cells,
// head in cell zero and tail in cell count-1, so the list order is the cell
// order. Push front, push back, pop front and pop back finish in the cycle the
// transaction is accepted: the chain shifts right, loads the cell after the
// tail, shifts left, or simply drops the tail, and the one result is registered
// for the output side. Listing and removal by value rotate the chain one cell
// per cycle, head wrapping to the tail, until every element has passed cell
// zero and the original order is back. Listing sends one result per element,
// pausing while the output side stalls. Removal drops the first element equal
// to the requested value as it passes the head and reports it after the walk.
// Empty, not-found and full conditions are reported in the status field, and a
// push into a full deque is dropped. Request codes six and seven are accepted
// and produce no result. A new request is accepted once the previous one is
// finished and the output register is free or being emptied in that cycle.
module doubly_linked_deque #(
    parameter int DEPTH = dld_pkg::DLD_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         req_type,
    input  logic signed [dld_pkg::VALUE_W-1:0] item_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [dld_pkg::VALUE_W-1:0] result_value,
    output logic                               last_result
);
    import dld_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_cmd_t          cmd;
    logic [CNT_W-1:0]   tgt;
    logic [CNT_W-1:0]   count;
    logic [VALUE_W-1:0] cell_val [DEPTH];
    logic [VALUE_W-1:0] tail_val;

    // The sequencer owns the element count and the result register.
    dld_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .item_value   (item_value),
        .head_val     (cell_val[0]),
        .tail_val     (tail_val),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .last_result  (last_result),
        .cmd          (cmd),
        .tgt          (tgt),
        .count        (count)
    );

    // Each cell takes from its neighbors; the ends of the chain take the
    // broadcast data in place of a missing neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_val;
        logic [VALUE_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = cmd.data;
        end
        else
        begin : g_inner_l
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = cmd.data;
        end
        else
        begin : g_inner_r
            assign right_val = cell_val[i+1];
        end

        dld_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .tgt       (tgt),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[i])
        );
    end

    // The tail cell is the one whose position is count-1; its value is picked
    // by a one-hot AND-OR over the chain for pop back.
    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count == CNT_W'(i + 1))
                tail_val = tail_val | cell_val[i];
        end
    end

endmodule

// ----- src/dld_cell.sv -----
// One storage cell of the element chain; cell zero holds the head.
module dld_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                      clk,
    input  dld_pkg::cell_cmd_t        cmd,
    input  logic [CNT_W-1:0]          tgt,
    input  logic [dld_pkg::VALUE_W-1:0] left_val,
    input  logic [dld_pkg::VALUE_W-1:0] right_val,
    output logic [dld_pkg::VALUE_W-1:0] val
);
    import dld_pkg::*;

    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] val_next;
    logic               is_tgt;

    assign is_tgt = (tgt == CNT_W'(CELL_IDX));

    always_comb
    begin
        case (cmd.op)
            OP_SHL:  val_next = right_val;
            OP_SHR:  val_next = left_val;
            OP_LOAD: val_next = is_tgt ? cmd.data : val_reg;
            // The head wraps around to the tail cell, everything else moves up.
            OP_ROT:  val_next = is_tgt ? cmd.data : right_val;
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- src/dld_ctrl.sv -----
// Request sequencer: element count, chain commands, walks and result register.
module dld_ctrl #(
    parameter int DEPTH = dld_pkg::DLD_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         req_type,
    input  logic signed [dld_pkg::VALUE_W-1:0] item_value,
    input  logic [dld_pkg::VALUE_W-1:0]        head_val,
    input  logic [dld_pkg::VALUE_W-1:0]        tail_val,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [dld_pkg::VALUE_W-1:0] result_value,
    output logic                               last_result,
    output dld_pkg::cell_cmd_t                 cmd,
    output logic [CNT_W-1:0]                   tgt,
    output logic [CNT_W-1:0]                   count
);
    import dld_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] result_reg, result_next;
    logic               last_reg, last_next;

    logic slot_free;
    logic accept;
    logic empty;
    logic full;
    logic match;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign match     = (head_val == key_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !empty)
                begin
                    if (req_type == REQ_LIST)
                        state_next = ST_LIST;
                    else if (req_type == REQ_REMOVE)
                        state_next = ST_FIND;
                end
            end
            ST_LIST:
            begin
                if (slot_free && remain_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            ST_FIND:
            begin
                if (remain_reg == CNT_W'(1))
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op         = OP_HOLD;
        cmd.data       = item_value;
        tgt            = count_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        result_next    = result_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LIST:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                                result_next    = '0;
                                last_next      = 1'b1;
                            end
                            else
                                remain_next = count_reg;
                        end
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            result_next    = '0;
                            last_next      = 1'b1;
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg + CNT_W'(1);
                                cmd.op      = (req_type == REQ_PUSH_FRONT) ? OP_SHR : OP_LOAD;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                                result_next = '0;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg - CNT_W'(1);
                                if (req_type == REQ_POP_FRONT)
                                begin
                                    cmd.op      = OP_SHL;
                                    result_next = head_val;
                                end
                                else
                                    result_next = tail_val;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                                result_next    = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                found_next  = 1'b0;
                                key_next    = item_value;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LIST:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_ROT;
                    cmd.data       = head_val;
                    tgt            = count_reg - CNT_W'(1);
                    remain_next    = remain_reg - CNT_W'(1);
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    result_next    = head_val;
                    last_next      = (remain_reg == CNT_W'(1));
                end
            end
            ST_FIND:
            begin
                remain_next = remain_reg - CNT_W'(1);
                if (!found_reg && match)
                begin
                    // Drop the first match; the rest keep rotating into place.
                    cmd.op     = OP_SHL;
                    count_next = count_reg - CNT_W'(1);
                    found_next = 1'b1;
                end
                else
                begin
                    cmd.op   = OP_ROT;
                    cmd.data = head_val;
                    tgt      = count_reg - CNT_W'(1);
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = found_reg ? STAT_OK : STAT_NOT_FOUND;
                    result_next    = found_reg ? key_reg : '0;
                    last_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        result_reg <= result_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign last_result  = last_reg;
    assign count        = count_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the doubly linked deque: directed and random requests.
module testbench;

    import dld_pkg::*;

    // Request codes that the block must accept and ignore.
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    // A listing of a full deque is the longest burst of results.
    localparam int DRAIN_CYCLES = DLD_DEPTH + 40;

    typedef struct {
        status_t            st;
        logic signed [31:0] value;
        logic               last;
    } result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type = REQ_LIST;
    logic signed [31:0] item_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic               last_result;

    // Contents of the deque as it should be, head first.
    logic signed [31:0] deque_image[$];
    // Results owed by the block, oldest first.
    result_t            owed_results[$];
    int                 error_count = 0;
    // When set, neither side inserts any idle cycles.
    bit                 steady = 1'b0;

    doubly_linked_deque uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .last_result  (last_result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Small values give duplicates so that removal must take the first match.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 3);
        if (r < 35)
            return 32'sh7fff_ffff;
        if (r < 40)
            return 32'sh8000_0000;
        if (r < 45)
            return -32'sd1;
        return $urandom;
    endfunction

    // A value to remove: usually one that is present.
    function automatic logic signed [31:0] pick_target();
        if (deque_image.size() > 0 && $urandom_range(0, 99) < 70)
            return deque_image[$urandom_range(0, deque_image.size() - 1)];
        return pick_value();
    endfunction

    // Update the deque image for one request and queue the results it owes.
    function automatic void apply_request(input logic [2:0] code,
                                          input logic signed [31:0] val);
        result_t            r;
        logic signed [31:0] taken;
        int                 hit;
        r.value = '0;
        r.last  = 1'b1;
        r.st    = STAT_OK;
        case (code)
            REQ_LIST:
            begin
                if (deque_image.size() == 0)
                begin
                    r.st = STAT_EMPTY;
                    owed_results.push_back(r);
                end
                else
                begin
                    foreach (deque_image[i])
                    begin
                        r.value = deque_image[i];
                        r.last  = (i == deque_image.size() - 1);
                        owed_results.push_back(r);
                    end
                end
            end
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (deque_image.size() >= DLD_DEPTH)
                    r.st = STAT_FULL;
                else if (code == REQ_PUSH_FRONT)
                    deque_image.push_front(val);
                else
                    deque_image.push_back(val);
                owed_results.push_back(r);
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (deque_image.size() == 0)
                    r.st = STAT_EMPTY;
                else if (code == REQ_POP_FRONT)
                    r.value = deque_image.pop_front();
                else
                    r.value = deque_image.pop_back();
                owed_results.push_back(r);
            end
            REQ_REMOVE:
            begin
                if (deque_image.size() == 0)
                begin
                    r.st = STAT_EMPTY;
                end
                else
                begin
                    hit = -1;
                    foreach (deque_image[i])
                        if (hit < 0 && deque_image[i] == val)
                            hit = i;
                    if (hit < 0)
                    begin
                        r.st = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        taken = deque_image[hit];
                        deque_image.delete(hit);
                        r.value = taken;
                    end
                end
                owed_results.push_back(r);
            end
            default:
            begin
                // Spare codes leave the deque alone and owe nothing.
            end
        endcase
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    task automatic issue_request(input logic [2:0] code, input logic signed [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= code;
        item_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        apply_request(code, val);
    endtask

    // One random request with weights that keep the deque partly filled.
    task automatic issue_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            issue_request(REQ_PUSH_FRONT, pick_value());
        else if (r < 44)
            issue_request(REQ_PUSH_BACK, pick_value());
        else if (r < 56)
            issue_request(REQ_POP_FRONT, pick_value());
        else if (r < 68)
            issue_request(REQ_POP_BACK, pick_value());
        else if (r < 84)
            issue_request(REQ_REMOVE, pick_target());
        else if (r < 96)
            issue_request(REQ_LIST, pick_value());
        else if (r < 98)
            issue_request(REQ_SPARE_A, pick_value());
        else
            issue_request(REQ_SPARE_B, pick_value());
    endtask

    // Listing, popping and removal on an empty deque report an empty status.
    task automatic test_empty_requests();
        issue_request(REQ_LIST, 32'sd0);
        issue_request(REQ_POP_FRONT, 32'sd0);
        issue_request(REQ_POP_BACK, -32'sd1);
        issue_request(REQ_REMOVE, 32'sd5);
    endtask

    // Spare codes are taken and dropped without a result.
    task automatic test_spare_codes();
        issue_request(REQ_SPARE_A, -32'sd1);
        issue_request(REQ_SPARE_B, 32'sd0);
        issue_request(REQ_PUSH_BACK, 32'sd9);
        issue_request(REQ_SPARE_B, 32'sh5555_5555);
        issue_request(REQ_LIST, 32'sd0);
        issue_request(REQ_POP_FRONT, 32'sd0);
    endtask

    // Extreme values through every operation, duplicates and a missing value.
    task automatic test_boundary_values();
        issue_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
        issue_request(REQ_PUSH_BACK, 32'sh8000_0000);
        issue_request(REQ_PUSH_BACK, 32'sd0);
        issue_request(REQ_PUSH_FRONT, -32'sd1);
        issue_request(REQ_PUSH_BACK, -32'sd1);
        issue_request(REQ_LIST, 32'sd0);
        issue_request(REQ_REMOVE, -32'sd1);
        issue_request(REQ_REMOVE, 32'sd12345);
        issue_request(REQ_LIST, 32'sd0);
        issue_request(REQ_POP_BACK, 32'sd0);
        issue_request(REQ_POP_FRONT, 32'sd0);
        issue_request(REQ_REMOVE, 32'sh8000_0000);
        issue_request(REQ_POP_FRONT, 32'sd0);
        issue_request(REQ_LIST, 32'sd0);
    endtask

    // Back-to-back traffic with no idle cycles on either side.
    task automatic test_steady_traffic();
        steady = 1'b1;
        repeat (10) issue_random();
        steady = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (10) issue_random();
    endtask

    // Fill every entry, overflow it, list it whole, then try three removals, push one and list again.
    task automatic test_fill_to_overflow();
        while (deque_image.size() < DLD_DEPTH)
            issue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
        repeat (3)
            issue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
        issue_request(REQ_LIST, 32'sd0);
        repeat (3) issue_request(REQ_REMOVE, pick_target());
        issue_request(REQ_PUSH_BACK, pick_value());
        issue_request(REQ_LIST, 32'sd0);
    endtask

    // Empty the deque from both ends, then pop it while empty.
    task automatic test_drain();
        while (deque_image.size() > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_request(REQ_REMOVE, pick_target());
            else
                issue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, 32'sd0);
        end
        issue_request(REQ_POP_BACK, 32'sd0);
        issue_request(REQ_LIST, 32'sd0);
    endtask

    // The output side stalls at random, with steady stretches in between.
    initial
    begin : drive_out_ready
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Each accepted result is matched against the oldest owed one.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: status %0d value %0d last %0b",
                       status, result_value, last_result);
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    error_count++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", want.value, result_value);
                    error_count++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0b, got %0b", want.last, last_result);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_requests();
        test_spare_codes();
        test_boundary_values();
        test_steady_traffic();
        test_random_mix();
        test_fill_to_overflow();
        test_drain();
        in_valid <= 1'b0;
        // Wait for every owed result, then watch for stray ones.
        while (owed_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #40000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- doubly_linked_deque.f -----
src/dld_pkg.sv
src/dld_cell.sv
src/dld_ctrl.sv
src/doubly_linked_deque.sv
tb/testbench.sv
